/* rtl/k_way_sorted_merge_core_macros.svh */
// Assertion macros shared by the k-way merge RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef K_WAY_SORTED_MERGE_CORE_MACROS_SVH
`define K_WAY_SORTED_MERGE_CORE_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define KWM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define KWM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* rtl/kwm_pkg.sv */
// Shared types and constants of the k-way sorted merge core.
// No dependencies; imported by the core, the minimum unit and the testbench.
package kwm_pkg;

    localparam int ACTION_W   = 2;
    localparam int LIST_IDX_W = 3;
    localparam int POS_W      = 6;
    localparam int VALUE_W    = 32;
    localparam int CNT_CFG_W  = 4;
    localparam int LEN_CFG_W  = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    // Slave-side tdata layout, lowest bit first.
    localparam int IN_LIST_LSB  = 0;
    localparam int IN_POS_LSB   = IN_LIST_LSB + LIST_IDX_W;
    localparam int IN_VALUE_LSB = IN_POS_LSB + POS_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LIST_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_LENGTH = 2'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_POP     = 2'd1,
        ACT_RESTART = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2,
        ST_EMIT   = 2'd3
    } t_state;

endpackage

/* rtl/k_way_sorted_merge_core.sv */
// K-way sorted merge core: value store, list sequencer and result register.
// Depends on kwm_pkg, kwm_ram, kwm_min_unit and the assertion macro header.
//
// Usage: the slave stream carries one command per transfer. tuser holds the
// action (load, pop, restart); tdata holds list index, position and value.
// A load writes one element into the store, a restart rewinds every list and
// arms list_count * list_length pops, a pop returns the next smallest value.
// Each pop gives one master-stream transfer: tdata is the value, tuser is 1
// when a value came out (0 once the merge is exhausted), tlast marks the final
// value. Loads and restarts give no transfer.
// A pop scans the list heads one list per cycle through the shared comparator
// and the store's registered read port, then passes the finish and emit states
// to the result register; a pop with a zero remaining count goes straight to emit.
// The next command is taken once the pop has returned to idle.
// The core takes no new command while a pop is in flight; it keeps accepting
// while a finished result waits, and a pop waits in its last step while the
// receiver stalls and the result register is full.
// Reset clears read positions, the remaining count and the output; the store
// keeps whatever it held and needs loading before a merge.
// The configuration port is always ready; write it only while the core is idle.
module k_way_sorted_merge_core
    import kwm_pkg::*;
#(
    parameter int MAX_LISTS  = 8,
    parameter int MAX_LENGTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: list_index[2:0], position[8:3], value[40:9], zero pad [47:41]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: action[1:0]
    input  logic [ACTION_W-1:0]   i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: value_res[31:0]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: valid_res[0]
    output logic                  o_m_axis_tuser,
    output logic                  o_m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "k_way_sorted_merge_core_macros.svh"

    localparam int DEPTH = MAX_LISTS * MAX_LENGTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(MAX_LISTS);
    localparam int KW    = $clog2(MAX_LISTS + 1);
    localparam int HW    = $clog2(MAX_LENGTH + 1);
    localparam int RW    = $clog2(DEPTH + 1);

    // Configuration
    logic [CNT_CFG_W-1:0] r_list_count;
    logic [LEN_CFG_W-1:0] r_list_length;
    logic [KW-1:0]        w_k;
    logic [HW-1:0]        w_h;

    // Input fields
    logic                      w_in_xfer;
    t_action                   w_action;
    logic [LIST_IDX_W-1:0]     w_in_list;
    logic [POS_W-1:0]          w_in_pos;
    logic [VALUE_W-1:0]        w_in_value;

    // Sequencer and merge state
    t_state          r_state;
    t_state          n_state;
    logic [HW-1:0]   r_rpos [MAX_LISTS];
    logic [RW-1:0]   r_remaining;
    logic [KW-1:0]   r_idx;
    logic [LW-1:0]   w_idx;
    logic [HW-1:0]   w_idx_pos;
    logic            w_issue;
    logic            r_pend_valid;
    logic [LW-1:0]   r_pend_list;
    logic [HW-1:0]   r_pend_pos;

    // Store ports
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [AW-1:0]       w_raddr;
    logic [VALUE_W-1:0]  w_rdata;

    // Minimum unit
    logic                      w_clear;
    logic                      w_found;
    logic signed [VALUE_W-1:0] w_best_value;
    logic [LW-1:0]             w_best_list;
    logic [HW-1:0]             w_best_pos;

    // Result staging and output register
    logic [VALUE_W-1:0] r_res_value;
    logic               r_res_valid;
    logic               r_res_last;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_user;
    logic               r_out_last;
    logic               w_slot_free;

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_action   = t_action'(i_s_axis_tuser);
    assign w_in_list  = i_s_axis_tdata[IN_LIST_LSB +: LIST_IDX_W];
    assign w_in_pos   = i_s_axis_tdata[IN_POS_LSB +: POS_W];
    assign w_in_value = i_s_axis_tdata[IN_VALUE_LSB +: VALUE_W];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_count  <= CNT_CFG_W'(1);
            r_list_length <= LEN_CFG_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LIST_COUNT:  r_list_count  <= i_cfg_data[CNT_CFG_W-1:0];
                CFG_LIST_LENGTH: r_list_length <= i_cfg_data[LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate the registers to the built store size.
    assign w_k = (32'(r_list_count) > MAX_LISTS) ? KW'(MAX_LISTS) : KW'(r_list_count);
    assign w_h = (32'(r_list_length) > MAX_LENGTH) ? HW'(MAX_LENGTH) : HW'(r_list_length);

    // Store write: drop loads that fall outside the store.
    assign w_we = w_in_xfer && (w_action == ACT_LOAD)
                  && (32'(w_in_list) < MAX_LISTS) && (32'(w_in_pos) < MAX_LENGTH);
    assign w_waddr = AW'(32'(w_in_list) * MAX_LENGTH + 32'(w_in_pos));

    // Head read for the list under scan.
    assign w_idx     = r_idx[LW-1:0];
    assign w_idx_pos = r_rpos[w_idx];
    assign w_issue   = (r_state == ST_SCAN) && (r_idx < w_k);
    assign w_raddr   = AW'(32'(w_idx) * MAX_LENGTH + 32'(w_idx_pos));

    kwm_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_in_value),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_clear = w_in_xfer && (w_action == ACT_POP);

    kwm_min_unit #(
        .LW(LW),
        .HW(HW)
    ) u_min (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (w_clear),
        .i_sample_valid(r_pend_valid),
        .i_value       ($signed(w_rdata)),
        .i_list        (r_pend_list),
        .i_pos         (r_pend_pos),
        .o_found       (w_found),
        .o_value       (w_best_value),
        .o_list        (w_best_list),
        .o_pos         (w_best_pos)
    );

    assign w_slot_free     = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && (w_action == ACT_POP)) begin
                    n_state = (r_remaining == '0) ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!w_issue) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Scan counter and the pending-compare stage that tracks the store latency.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_pend_valid <= w_issue && (w_idx_pos < w_h);
            if (w_clear) begin
                r_idx <= '0;
            end else if (w_issue) begin
                r_idx <= r_idx + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_list <= w_idx;
        r_pend_pos  <= w_idx_pos;
    end

    // Read positions and remaining count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LISTS; i++) begin
                r_rpos[i] <= '0;
            end
            r_remaining <= '0;
        end else if (w_in_xfer && (w_action == ACT_RESTART)) begin
            for (int i = 0; i < MAX_LISTS; i++) begin
                r_rpos[i] <= '0;
            end
            r_remaining <= RW'(32'(w_k) * 32'(w_h));
        end else if (r_state == ST_FINISH) begin
            if (w_found) begin
                r_rpos[w_best_list] <= w_best_pos + HW'(1);
                r_remaining         <= r_remaining - RW'(1);
            end else begin
                r_remaining <= '0;
            end
        end
    end

    // Stage the result; an exhausted pop reports all zeros.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_res_value <= '0;
            r_res_valid <= 1'b0;
            r_res_last  <= 1'b0;
        end else if ((r_state == ST_FINISH) && w_found) begin
            r_res_value <= w_best_value;
            r_res_valid <= 1'b1;
            r_res_last  <= (r_remaining == RW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_EMIT) && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_EMIT) && w_slot_free) begin
            r_out_value <= r_res_value;
            r_out_user  <= r_res_valid;
            r_out_last  <= r_res_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

    `KWM_ASSERT(a_remaining_no_rise,
        !$past(w_in_xfer && (w_action == ACT_RESTART)) |-> r_remaining <= $past(r_remaining),
        "remaining count rose without a restart")
    `KWM_ASSERT(a_found_takes_one,
        (r_state == ST_FINISH) && w_found |=> r_remaining == $past(r_remaining) - RW'(1),
        "emitted value did not consume exactly one element")
    `KWM_ASSERT(a_last_has_value,
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser,
        "last flag on an exhausted result")
    `KWM_ASSERT(a_scan_no_input,
        (r_state == ST_SCAN) || (r_state == ST_FINISH) |-> !w_we,
        "store written during a head scan")
    `KWM_ASSERT_ALWAYS(a_reset_clears,
        !i_rst_n |=> !o_m_axis_tvalid && (r_state == ST_IDLE) && (r_remaining == '0),
        "reset left the core busy")

endmodule

/* rtl/kwm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/kwm_min_unit.sv */
// Running-minimum unit: one signed comparator shared over all list heads.
// Depends on kwm_pkg for the value width.
module kwm_min_unit
    import kwm_pkg::*;
#(
    parameter int LW = 3,
    parameter int HW = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  logic                      i_sample_valid,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic [LW-1:0]             i_list,
    input  logic [HW-1:0]             i_pos,
    output logic                      o_found,
    output logic signed [VALUE_W-1:0] o_value,
    output logic [LW-1:0]             o_list,
    output logic [HW-1:0]             o_pos
);

    logic                      r_found;
    logic signed [VALUE_W-1:0] r_value;
    logic [LW-1:0]             r_list;
    logic [HW-1:0]             r_pos;
    logic                      w_take;

    // Strict less-than keeps the lowest list index on equal heads.
    assign w_take = i_sample_valid && (!r_found || (i_value < r_value));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !i_clear) begin
            r_value <= i_value;
            r_list  <= i_list;
            r_pos   <= i_pos;
        end
    end

    assign o_found = r_found;
    assign o_value = r_value;
    assign o_list  = r_list;
    assign o_pos   = r_pos;

endmodule

/* dv/tb_k_way_sorted_merge_core.sv */
// Self-checking testbench for k_way_sorted_merge_core: directed and random merge
// sessions with a transaction-level merge predictor and randomized stream stalls.
// Depends on kwm_pkg and the core RTL only.
module tb_k_way_sorted_merge_core;
    import kwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_LISTS     = 8;
    localparam int N_LEN       = 64;
    localparam int TARGET_CMDS = 1350;
    localparam int SETTLE      = 16;   // idle margin after the last result
    localparam int SINK_HOLD   = 300;
    localparam int MAX_PRINTS  = 40;

    localparam logic [ACTION_W-1:0]  ACT_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               valid;
        logic               last;
    } t_merge_result;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic [ACTION_W-1:0]   i_s_axis_tuser  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    // merge predictor state
    logic signed [VALUE_W-1:0] elem_mem [N_LISTS*N_LEN];
    bit                        elem_set [N_LISTS*N_LEN];
    logic [6:0]                rd_pos   [N_LISTS];
    logic [9:0]                remaining = '0;
    logic [CNT_CFG_W-1:0]      cfg_count = 4'd1;
    logic [LEN_CFG_W-1:0]      cfg_length = 7'd1;

    t_merge_result results_due[$];

    int  errors        = 0;
    int  cmds_sent     = 0;
    int  merges_armed  = 0;
    int  values_seen   = 0;
    int  dry_seen      = 0;
    bit  idle_on       = 1'b0;
    int  hold_seq      = 0;
    int  hold_seen     = 0;
    int  hold_left     = 0;
    int  sink_gap      = 0;
    bit  sink_idle     = 1'b1;

    k_way_sorted_merge_core #(
        .MAX_LISTS (N_LISTS),
        .MAX_LENGTH(N_LEN)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("Timeout: %0d results still due", results_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic int lists_used();
        return (cfg_count > N_LISTS) ? N_LISTS : int'(cfg_count);
    endfunction

    function automatic int length_used();
        return (cfg_length > N_LEN) ? N_LEN : int'(cfg_length);
    endfunction

    // Store entry that the next pop would read without it ever being loaded.
    function automatic int unloaded_head();
        int k;
        int h;
        k = lists_used();
        h = length_used();
        if (remaining == 0) return -1;
        for (int i = 0; i < k; i++) begin
            if (rd_pos[i] < h && !elem_set[i*N_LEN + rd_pos[i]]) return i*N_LEN + rd_pos[i];
        end
        return -1;
    endfunction

    function automatic void apply_cmd(input logic [ACTION_W-1:0] act,
                                      input logic [LIST_IDX_W-1:0] lst,
                                      input logic [POS_W-1:0] pos,
                                      input logic [VALUE_W-1:0] val);
        t_merge_result             r;
        logic signed [VALUE_W-1:0] best;
        logic signed [VALUE_W-1:0] head;
        int                        best_list;
        int                        k;
        int                        h;
        bit                        found;
        k = lists_used();
        h = length_used();
        r = '0;
        best = '0;
        best_list = 0;
        found = 1'b0;
        case (act)
            ACT_LOAD: begin
                elem_mem[lst*N_LEN + pos] = val;
                elem_set[lst*N_LEN + pos] = 1'b1;
            end
            ACT_RESTART: begin
                foreach (rd_pos[i]) rd_pos[i] = '0;
                remaining = 10'(k * h);
                merges_armed++;
            end
            ACT_POP: begin
                if (remaining != 0) begin
                    for (int i = 0; i < k; i++) begin
                        if (rd_pos[i] < h) begin
                            head = elem_mem[i*N_LEN + rd_pos[i]];
                            if (!found || head < best) begin
                                found = 1'b1;
                                best = head;
                                best_list = i;
                            end
                        end
                    end
                    // all lists in use ran dry before the count did
                    if (!found) begin
                        remaining = '0;
                    end else begin
                        rd_pos[best_list] = rd_pos[best_list] + 7'd1;
                        remaining = remaining - 10'd1;
                        r.value = best;
                        r.valid = 1'b1;
                        r.last = (remaining == 0);
                    end
                end
                results_due.push_back(r);
            end
            default: ;
        endcase
    endfunction

    task automatic send_cmd(input logic [ACTION_W-1:0] act,
                            input int lst,
                            input int pos,
                            input logic [VALUE_W-1:0] val);
        int                    gap;
        logic [IN_DATA_W-1:0]  word;
        logic [LIST_IDX_W-1:0] lst_f;
        logic [POS_W-1:0]      pos_f;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        lst_f = LIST_IDX_W'(lst);
        pos_f = POS_W'(pos);
        word = '0;
        word[IN_LIST_LSB +: LIST_IDX_W] = lst_f;
        word[IN_POS_LSB +: POS_W] = pos_f;
        word[IN_VALUE_LSB +: VALUE_W] = val;
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= word;
        i_s_axis_tuser <= act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        apply_cmd(act, lst_f, pos_f, val);
        if (act != ACT_UNUSED) cmds_sent++;
    endtask

    // Pop, unless the pop would read a store entry that was never loaded.
    task automatic pop_or_fill();
        int idx;
        idx = unloaded_head();
        if (idx >= 0) send_cmd(ACT_LOAD, idx / N_LEN, idx % N_LEN, $urandom);
        else send_cmd(ACT_POP, $urandom_range(0, 7), $urandom_range(0, 63), $urandom);
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_LIST_COUNT) cfg_count = data[CNT_CFG_W-1:0];
        else if (idx == CFG_LIST_LENGTH) cfg_length = data;
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] cnt_data,
                                input logic [CFG_DATA_W-1:0] len_data,
                                input bit spare);
        wait_idle();
        write_reg(CFG_LIST_COUNT, cnt_data);
        write_reg(CFG_LIST_LENGTH, len_data);
        if (spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Load sorted lists for the current setting, restart and drain the merge.
    task automatic run_merge(input bit squeeze);
        int k;
        int h;
        int n_pops;
        int vals[$];
        bit ties;
        k = lists_used();
        h = length_used();
        for (int i = 0; i < k; i++) begin
            vals.delete();
            ties = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < h; j++) vals.push_back(ties ? $urandom_range(0, 6) - 3 : $urandom);
            if (h > 0 && $urandom_range(0, 5) == 0) vals[$urandom_range(0, h-1)] = VAL_MIN;
            if (h > 0 && $urandom_range(0, 5) == 0) vals[$urandom_range(0, h-1)] = VAL_MAX;
            vals.sort();
            for (int j = 0; j < h; j++) begin
                if ($urandom_range(0, 15) == 0)
                    send_cmd(ACT_UNUSED, $urandom_range(0, 7), $urandom_range(0, 63), $urandom);
                send_cmd(ACT_LOAD, i, j, vals[j]);
            end
        end
        send_cmd(ACT_RESTART, $urandom_range(0, 7), $urandom_range(0, 63), $urandom);
        if (squeeze) begin
            idle_on = 1'b0;
            hold_seq <= hold_seq + 1;
        end
        n_pops = k * h + $urandom_range(1, 2);
        for (int i = 0; i < n_pops; i++) begin
            if (!squeeze) begin
                case ($urandom_range(0, 19))
                    0: send_cmd(ACT_UNUSED, $urandom_range(0, 7), $urandom_range(0, 63), $urandom);
                    1: send_cmd(ACT_LOAD, $urandom_range(0, 7), $urandom_range(0, 63), $urandom);
                    default: ;
                endcase
            end
            pop_or_fill();
        end
    endtask

    // Commands in no particular order: stray loads, early restarts, dry pops.
    task automatic run_noise(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_cmd(ACT_LOAD, $urandom_range(0, 7), $urandom_range(0, 63), $urandom);
                3: send_cmd(ACT_RESTART, $urandom_range(0, 7), $urandom_range(0, 63), $urandom);
                4: send_cmd(ACT_UNUSED, $urandom_range(0, 7), $urandom_range(0, 63), $urandom);
                default: pop_or_fill();
            endcase
        end
    endtask

    task automatic test_cold_pop();
        idle_on = 1'b1;
        send_cmd(ACT_POP, 0, 0, '0);
        send_cmd(ACT_UNUSED, 7, 63, '1);
        send_cmd(ACT_POP, 7, 63, '1);
    endtask

    task automatic test_value_extremes();
        program_regs(7'd2, 7'd3, 1'b0);
        send_cmd(ACT_LOAD, 0, 0, VAL_MIN);
        send_cmd(ACT_LOAD, 0, 1, -32'sd1);
        send_cmd(ACT_LOAD, 0, 2, VAL_MAX);
        send_cmd(ACT_LOAD, 1, 0, VAL_MIN);
        send_cmd(ACT_LOAD, 1, 1, '0);
        send_cmd(ACT_LOAD, 1, 2, VAL_MAX);
        send_cmd(ACT_LOAD, 7, 63, 32'h5555_5555);
        send_cmd(ACT_RESTART, 5, 42, 32'haaaa_aaaa);
        repeat (8) pop_or_fill();
    endtask

    task automatic test_size_extremes();
        program_regs(7'd15, 7'd1, 1'b1);   // count saturates to the list maximum
        run_merge(1'b0);
        program_regs(7'd1, 7'd127, 1'b0);  // length saturates to the list depth
        run_merge(1'b0);
        program_regs(7'd0, 7'd4, 1'b0);    // no lists at all
        run_merge(1'b0);
        program_regs(7'd3, 7'd0, 1'b0);    // empty lists
        run_merge(1'b0);
    endtask

    // Shrink the list count after list 0 ran dry: the pending count must clear.
    task automatic test_shrink_mid_merge();
        program_regs(7'd2, 7'd2, 1'b0);
        send_cmd(ACT_LOAD, 0, 0, 32'd1);
        send_cmd(ACT_LOAD, 0, 1, 32'd2);
        send_cmd(ACT_LOAD, 1, 0, 32'd3);
        send_cmd(ACT_LOAD, 1, 1, 32'd4);
        send_cmd(ACT_RESTART, 0, 0, '0);
        pop_or_fill();
        pop_or_fill();
        program_regs(7'd1, 7'd2, 1'b0);
        pop_or_fill();
        pop_or_fill();
    endtask

    task automatic test_backpressure();
        program_regs(7'd4, 7'd4, 1'b0);
        run_merge(1'b1);
    endtask

    task automatic test_random_merges();
        logic [CFG_DATA_W-1:0] cnt_data;
        logic [CFG_DATA_W-1:0] len_data;
        int                    k;
        int                    h;
        while (cmds_sent < TARGET_CMDS) begin
            if ($urandom_range(0, 9) == 0) cnt_data = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(9, 127));
            else cnt_data = 7'($urandom_range(1, 8));
            case ($urandom_range(0, 11))
                0: len_data = 7'd0;
                1: len_data = 7'($urandom_range(64, 127));
                2: len_data = 7'($urandom_range(9, 63));
                default: len_data = 7'($urandom_range(1, 8));
            endcase
            program_regs(cnt_data, len_data, $urandom_range(0, 7) == 0);
            idle_on = ($urandom_range(0, 3) != 0);
            k = lists_used();
            h = length_used();
            if (k * h > 96 || $urandom_range(0, 3) == 0) run_noise($urandom_range(20, 40));
            else run_merge(1'b0);
        end
    endtask

    // Receiver: random stalls, an occasional long hold, and the result check.
    always @(posedge i_clk) begin : result_sink
        t_merge_result want;
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = SINK_HOLD;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (results_due.size() == 0) begin
                flag_error($sformatf("result with no pop pending: value %0d", $signed(o_m_axis_tdata)));
            end else begin
                want = results_due.pop_front();
                if (o_m_axis_tdata !== want.value)
                    flag_error($sformatf("value_res %0d, want %0d",
                                         $signed(o_m_axis_tdata), $signed(want.value)));
                if (o_m_axis_tuser !== want.valid)
                    flag_error($sformatf("valid_res %b, want %b", o_m_axis_tuser, want.valid));
                if (o_m_axis_tlast !== want.last)
                    flag_error($sformatf("last %b, want %b", o_m_axis_tlast, want.last));
                if (want.valid) values_seen++;
                else dry_seen++;
            end
            sink_gap = sink_idle ? $urandom_range(0, 3) : 0;
            if ($urandom_range(0, 63) == 0) sink_idle = !sink_idle;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    initial begin
        foreach (elem_set[i]) elem_set[i] = 1'b0;
        foreach (elem_mem[i]) elem_mem[i] = '0;
        foreach (rd_pos[i]) rd_pos[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_cold_pop();
        test_value_extremes();
        test_size_extremes();
        test_shrink_mid_merge();
        test_backpressure();
        test_random_merges();
        wait_idle();
        $display("Sent %0d commands over %0d armed merges; checked %0d merged values and %0d dry pops.",
                 cmds_sent, merges_armed, values_seen, dry_seen);
        $display("Covered list counts 0 to 8 with saturation, lengths 0 to 64, and a %0d-cycle stall.",
                 SINK_HOLD);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
